>>> design/awmr_pkg.sv
`timescale 1ns / 1ps
package awmr_pkg;

   localparam int NUM_AXES = 3;
   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = 16;
   localparam int RATIO_W  = 32;
   localparam int RING_W   = NUM_AXES * SAMPLE_W;
   localparam int OUT_W    = NUM_AXES * RATIO_W;
   localparam int FLAG_W   = 2 * NUM_AXES;

   localparam logic [RATIO_W-1:0] RATIO_MAX = {1'b0, {(RATIO_W - 1){1'b1}}};
   localparam logic [RATIO_W-1:0] RATIO_MIN = {1'b1, {(RATIO_W - 1){1'b0}}};

   typedef struct packed {
      logic fetch;
      logic update;
   } win_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } lane_ctrl_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic               zero_mean;
      logic               clipped;
   } lane_result_type;

endpackage

>>> design/accel_window_mean_ratio.sv
`timescale 1ns / 1ps
// a word is taken only in IDLE and passes UPDATE, LOAD, DIVIDE and FINISH before the
// output register raises rsp_tvalid; the pace is set by the bit-serial restoring
// divider that forms one quotient bit per cycle in each axis lane
// a finished result waits in the output register; the next word is taken meanwhile
// reset: synchronous, empties the window, clears the sums and drops any pending result;
// the ring itself is not cleared and needs no clearing pass
module accel_window_mean_ratio
   import awmr_pkg::*;
#(
   parameter int WINDOW_DEPTH = 100
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [RING_W-1:0] req_tdata,  // sample_x, sample_y, sample_z
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata,  // ratio_x, ratio_y, ratio_z
   output logic [FLAG_W-1:0] rsp_tuser   // zero_mean_x, zero_mean_y, zero_mean_z,
                                         // clipped_x, clipped_y, clipped_z
);

   localparam int CountW = $clog2(WINDOW_DEPTH + 1);
   localparam int MagW   = SAMPLE_W + CountW;
   localparam int NumW   = MagW + FRAC_W;
   localparam int StepW  = $clog2(NumW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic [StepW-1:0]  step_cnt_ff, step_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [FLAG_W-1:0] rsp_user_ff, rsp_user_in;
   logic signed [SAMPLE_W-1:0] sample_ff [NUM_AXES];
   logic signed [SAMPLE_W-1:0] sample_in [NUM_AXES];

   logic accept;
   logic out_free;
   win_ctrl_type    win_ctrl;
   lane_ctrl_type   lane_ctrl;
   lane_result_type lane_res [NUM_AXES];
   logic signed [MagW-1:0] sum [NUM_AXES];
   logic [CountW-1:0] count;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign win_ctrl.fetch  = accept;
   assign win_ctrl.update = (state_ff == ST_UPDATE);
   assign lane_ctrl.load  = (state_ff == ST_LOAD);
   assign lane_ctrl.step  = (state_ff == ST_DIVIDE);

   awmr_window #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock (clock),
      .reset (reset),
      .ctrl  (win_ctrl),
      .sample(sample_ff),
      .sum   (sum),
      .count (count)
   );

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      awmr_div_lane #(
         .WINDOW_DEPTH(WINDOW_DEPTH)
      ) u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .sample(sample_ff[a]),
         .count (count),
         .sum   (sum[a]),
         .result(lane_res[a])
      );
   end

   always_comb begin
      state_in     = state_ff;
      step_cnt_in  = step_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      sample_in    = sample_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int a = 0; a < NUM_AXES; a++) begin
                  sample_in[a] = req_tdata[a*SAMPLE_W +: SAMPLE_W];
               end
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            step_cnt_in = StepW'(NumW);
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            step_cnt_in = step_cnt_ff - 1'b1;
            if (step_cnt_ff == StepW'(1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               for (int a = 0; a < NUM_AXES; a++) begin
                  rsp_data_in[a*RATIO_W +: RATIO_W] = lane_res[a].ratio;
                  rsp_user_in[a]                   = lane_res[a].zero_mean;
                  rsp_user_in[NUM_AXES + a]        = lane_res[a].clipped;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_cnt_ff  <= step_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      sample_ff   <= sample_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_accept_starts_update : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPDATE))
      else $error("taken word did not start the window update");

   a_divide_ends : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && step_cnt_ff == StepW'(1)) |=> (state_ff == ST_FINISH))
      else $error("divider did not finish after the last quotient bit");

   a_zero_mean_ratio : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((!rsp_tuser[0] || rsp_tdata[31:0] == '0)
                   && (!rsp_tuser[1] || rsp_tdata[63:32] == '0)
                   && (!rsp_tuser[2] || rsp_tdata[95:64] == '0)))
      else $error("zero window sum with non-zero ratio");

endmodule

>>> design/awmr_window.sv
`timescale 1ns / 1ps
module awmr_window
   import awmr_pkg::*;
#(
   parameter int WINDOW_DEPTH = 100
) (
   input  logic                 clock,
   input  logic                 reset,
   input  win_ctrl_type         ctrl,
   input  logic signed [SAMPLE_W-1:0] sample [NUM_AXES],
   output logic signed [SAMPLE_W+$clog2(WINDOW_DEPTH+1)-1:0] sum [NUM_AXES],
   output logic [$clog2(WINDOW_DEPTH+1)-1:0] count
);

   localparam int CountW = $clog2(WINDOW_DEPTH + 1);
   localparam int MagW   = SAMPLE_W + CountW;
   localparam int SlotW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   logic [RING_W-1:0] ring [WINDOW_DEPTH];
   logic [RING_W-1:0] evict_ff;
   logic [RING_W-1:0] sample_word;

   logic [SlotW-1:0]  slot_ff, slot_in;
   logic [CountW-1:0] fill_ff, fill_in;
   logic signed [MagW-1:0] sum_ff [NUM_AXES];
   logic signed [MagW-1:0] sum_in [NUM_AXES];
   logic full;

   assign full = (fill_ff == CountW'(WINDOW_DEPTH));

   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         sample_word[a*SAMPLE_W +: SAMPLE_W] = sample[a];
         sum_in[a] = sum_ff[a] + MagW'(sample[a]);
         if (full) begin
            sum_in[a] = sum_in[a] - MagW'($signed(evict_ff[a*SAMPLE_W +: SAMPLE_W]));
         end
      end
      slot_in = (slot_ff == SlotW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      fill_in = full ? fill_ff : fill_ff + 1'b1;
   end

   // ring of past words, registered read
   always_ff @(posedge clock) begin
      if (ctrl.fetch) begin
         evict_ff <= ring[slot_ff];
      end
      if (ctrl.update) begin
         ring[slot_ff] <= sample_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            sum_ff[a] <= '0;
         end
      end else if (ctrl.update) begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            sum_ff[a] <= sum_in[a];
         end
      end
   end

   assign sum   = sum_ff;
   assign count = fill_ff;

endmodule

>>> design/awmr_div_lane.sv
`timescale 1ns / 1ps
module awmr_div_lane
   import awmr_pkg::*;
#(
   parameter int WINDOW_DEPTH = 100
) (
   input  logic                 clock,
   input  lane_ctrl_type        ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0] count,
   input  logic signed [SAMPLE_W+$clog2(WINDOW_DEPTH+1)-1:0] sum,
   output lane_result_type      result
);

   localparam int CountW = $clog2(WINDOW_DEPTH + 1);
   localparam int MagW   = SAMPLE_W + CountW;
   localparam int NumW   = MagW + FRAC_W;

   // num_ff shifts the dividend out at the top and the quotient in at the bottom
   logic [NumW-1:0] num_ff, num_in;
   logic [MagW-1:0] rem_ff, rem_in;
   logic [MagW-1:0] div_ff, div_in;
   logic negative_ff, negative_in;
   logic zero_ff, zero_in;

   logic [SAMPLE_W-1:0] sample_mag;
   logic [MagW-1:0]     sum_mag;
   logic [MagW-1:0]     prod;
   logic [MagW:0]       shifted;
   logic [MagW:0]       trial;
   logic                fits;
   logic                pos_over;
   logic                neg_over;

   always_comb begin
      sample_mag = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
      sum_mag    = sum[MagW-1] ? MagW'(-sum) : MagW'(sum);
      prod       = MagW'(sample_mag) * MagW'(count);
      shifted    = {rem_ff, num_ff[NumW-1]};
      fits       = (shifted >= {1'b0, div_ff});
      trial      = shifted - {1'b0, div_ff};

      num_in      = num_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      negative_in = negative_ff;
      zero_in     = zero_ff;
      if (ctrl.load) begin
         num_in      = {prod, {FRAC_W{1'b0}}};
         rem_in      = '0;
         div_in      = sum_mag;
         negative_in = sample[SAMPLE_W-1] ^ sum[MagW-1];
         zero_in     = (sum == '0);
      end else if (ctrl.step) begin
         num_in = {num_ff[NumW-2:0], fits};
         rem_in = fits ? trial[MagW-1:0] : shifted[MagW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      negative_ff <= negative_in;
      zero_ff     <= zero_in;
   end

   // saturation to q15.16
   always_comb begin
      pos_over = |num_ff[NumW-1:RATIO_W-1];
      neg_over = (|num_ff[NumW-1:RATIO_W])
               || (num_ff[RATIO_W-1] && (|num_ff[RATIO_W-2:0]));
      result.zero_mean = 1'b0;
      result.clipped   = 1'b0;
      if (zero_ff) begin
         result.ratio     = '0;
         result.zero_mean = 1'b1;
      end else if (negative_ff) begin
         if (neg_over) begin
            result.ratio   = RATIO_MIN;
            result.clipped = 1'b1;
         end else begin
            result.ratio = RATIO_W'(-num_ff[RATIO_W-1:0]);
         end
      end else begin
         if (pos_over) begin
            result.ratio   = RATIO_MAX;
            result.clipped = 1'b1;
         end else begin
            result.ratio = num_ff[RATIO_W-1:0];
         end
      end
   end

endmodule
